// ===== hdl/bgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  localparam int unsigned MaxLineDef = 2048;

  localparam logic [11:0] LineWidthRst   = 12'd640;
  localparam logic [15:0] FrameHeightRst = 16'd480;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgLineWidth   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  localparam int unsigned DescDepth = 2;
  localparam int unsigned PixDepth  = 4;

  localparam logic [9:0] Recip3 = 10'd683;

  // one bit per result that an input sample can release, in raster order
  localparam logic [3:0] JobAboveLeft = 4'b0001;
  localparam logic [3:0] JobAbove     = 4'b0010;
  localparam logic [3:0] JobLeft      = 4'b0100;
  localparam logic [3:0] JobHere      = 4'b1000;

  typedef enum logic [1:0] {
    ColRed,
    ColGreen,
    ColBlue
  } colour_e;

  typedef struct packed {
    logic [2:0][2:0][7:0] win;
    logic [15:0]          row;
    logic [10:0]          col;
    logic [3:0]           mask;
    logic                 top2;
    logic                 left2;
  } desc_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] row;
    logic [10:0] col;
    logic        last;
    logic        done;
  } pix_t;

  function automatic colour_e colour_at(input logic rpar, input logic cpar);
    colour_e c;
    if (!rpar) begin
      c = cpar ? ColBlue : ColGreen;
    end else begin
      c = cpar ? ColGreen : ColRed;
    end
    return c;
  endfunction

  function automatic logic [7:0] avg_div(input logic [9:0] sum, input logic [2:0] cnt);
    logic [19:0] prod;
    logic [7:0]  q;
    prod = 20'(sum) * 20'(Recip3);
    case (cnt)
      3'd1:    q = sum[7:0];
      3'd2:    q = sum[8:1];
      3'd3:    q = prod[18:11];
      3'd4:    q = sum[9:2];
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bgd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bgd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [W-1:0]    wdata_i,
  input  wire logic            pop_i,
  output logic      [W-1:0]    rdata_o,
  output logic                 full_o,
  output logic                 empty_o,
  output logic      [CntW-1:0] count_o
);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bgd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_front
  import bgd_pkg::*;
#(
  parameter int unsigned MAX_LINE = MaxLineDef,
  localparam int unsigned AW      = $clog2(MAX_LINE),
  localparam int unsigned WW      = $clog2(MAX_LINE + 1),
  localparam int unsigned CW      = (WW > 12) ? WW : 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [7:0]          raw_pixel_i,
  output logic                     full_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output desc_t                    desc_o,
  output logic                     desc_push_o,
  input  wire logic                desc_full_i
);

  logic [11:0]          line_width_q;
  logic [15:0]          frame_height_q;
  logic [15:0]          row_q, row_d;
  logic [AW-1:0]        col_q, col_d;
  logic                 busy_q;
  logic [7:0]           pix_q;
  logic [AW-1:0]        addr_q;
  logic [15:0]          orow_q;
  logic [10:0]          ocol_q;
  logic [3:0]           mask_q, mask_d;
  logic                 top2_q, left2_q;
  logic [2:0][2:0][7:0] win_q, win_d;

  logic [CW-1:0] lw_ext, w_eff, wm1, col_ext;
  logic [15:0]   h_eff, hm1;
  logic          accept, col_end, last_row, row_ge1, col_ge1;
  logic [7:0]    upper_rd, middle_rd;

  assign lw_ext = CW'(line_width_q);

  always_comb begin
    if (lw_ext < CW'(2)) begin
      w_eff = CW'(2);
    end else if (lw_ext > CW'(MAX_LINE)) begin
      w_eff = CW'(MAX_LINE);
    end else begin
      w_eff = lw_ext;
    end
  end

  assign h_eff    = (frame_height_q < 16'd2) ? 16'd2 : frame_height_q;
  assign wm1      = w_eff - CW'(1);
  assign hm1      = h_eff - 16'd1;
  assign col_ext  = CW'(col_q);
  assign col_end  = (col_ext == wm1);
  assign last_row = (row_q == hm1);
  assign row_ge1  = (row_q != '0);
  assign col_ge1  = (col_q != '0);

  assign full_o = busy_q | desc_full_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    mask_d = '0;
    if (row_ge1 && col_ge1) begin
      mask_d = mask_d | JobAboveLeft;
    end
    if (row_ge1 && col_end) begin
      mask_d = mask_d | JobAbove;
    end
    if (last_row && col_ge1) begin
      mask_d = mask_d | JobLeft;
    end
    if (last_row && col_end) begin
      mask_d = mask_d | JobHere;
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = upper_rd;
    win_d[1][2] = middle_rd;
    win_d[2][2] = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
      row_q          <= '0;
      col_q          <= '0;
      busy_q         <= 1'b0;
      win_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgLineWidth:   line_width_q   <= cfg_data_i[11:0];
          CfgFrameHeight: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      row_q  <= row_d;
      col_q  <= col_d;
      busy_q <= accept;
      if (busy_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= raw_pixel_i;
      addr_q  <= col_q;
      orow_q  <= row_q;
      ocol_q  <= 11'(col_q);
      mask_q  <= mask_d;
      top2_q  <= (row_q >= 16'd2);
      left2_q <= (col_ext >= CW'(2));
    end
  end

  bgd_ram #(
    .W     (8),
    .DEPTH (MAX_LINE)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (busy_q),
    .waddr_i (addr_q),
    .wdata_i (middle_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (upper_rd)
  );

  bgd_ram #(
    .W     (8),
    .DEPTH (MAX_LINE)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (busy_q),
    .waddr_i (addr_q),
    .wdata_i (pix_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (middle_rd)
  );

  assign desc_push_o  = busy_q & (mask_q != '0);
  assign desc_o.win   = win_d;
  assign desc_o.row   = orow_q;
  assign desc_o.col   = ocol_q;
  assign desc_o.mask  = mask_q;
  assign desc_o.top2  = top2_q;
  assign desc_o.left2 = left2_q;

endmodule

`default_nettype wire

// ===== hdl/bgd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_back
  import bgd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire desc_t desc_i,
  input  wire logic  desc_empty_i,
  output logic       desc_pop_o,
  output pix_t       pix_o,
  output logic       empty_o,
  input  wire logic  pop_i
);

  localparam int unsigned CntW = $clog2(PixDepth + 1);

  logic       hold_q;
  desc_t      cur_q;
  logic [3:0] rem_q;
  logic [3:0] sel, rem_next;
  logic       load, issue;

  logic [CntW-1:0] oq_cnt;
  logic            oq_full;
  pix_t            oq_wdata;

  logic        rc_hi, cc_hi, vt, vb, vl, vr, done;
  logic [15:0] jrow;
  logic [10:0] jcol;

  logic [2:0][2:0][7:0] sub;
  logic [1:0]           ri, cj;
  logic [9:0]           hsum, vsum, xsum, dsum;
  logic [2:0]           hcnt, vcnt, xcnt, dcnt;
  logic [7:0]           ctr;
  colour_e              colour;
  logic [2:0][9:0]      sum_d;
  logic [2:0][2:0]      cnt_d;

  logic            s1_valid_q;
  logic [2:0][9:0] s1_sum_q;
  logic [2:0][2:0] s1_cnt_q;
  logic [15:0]     s1_row_q;
  logic [10:0]     s1_col_q;
  logic            s1_last_q, s1_done_q;

  assign load       = ~hold_q & ~desc_empty_i;
  assign desc_pop_o = load;
  assign issue      = hold_q &
                      (({1'b0, oq_cnt} + (CntW + 1)'(s1_valid_q)) < (CntW + 1)'(PixDepth));

  assign sel      = rem_q & (~rem_q + 4'd1);
  assign rem_next = rem_q & ~sel;

  always_comb begin
    rc_hi = 1'b0;
    cc_hi = 1'b0;
    vt    = 1'b1;
    vb    = 1'b1;
    vl    = 1'b1;
    vr    = 1'b1;
    done  = 1'b0;
    jrow  = cur_q.row;
    jcol  = cur_q.col;
    unique case (sel)
      JobAboveLeft: begin
        jrow = cur_q.row - 16'd1;
        jcol = cur_q.col - 11'd1;
        vt   = cur_q.top2;
        vl   = cur_q.left2;
      end
      JobAbove: begin
        jrow  = cur_q.row - 16'd1;
        cc_hi = 1'b1;
        vt    = cur_q.top2;
        vr    = 1'b0;
      end
      JobLeft: begin
        jcol  = cur_q.col - 11'd1;
        rc_hi = 1'b1;
        vb    = 1'b0;
        vl    = cur_q.left2;
      end
      JobHere: begin
        rc_hi = 1'b1;
        cc_hi = 1'b1;
        vb    = 1'b0;
        vr    = 1'b0;
        done  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = 2'(i) + {1'b0, rc_hi};
        cj = 2'(j) + {1'b0, cc_hi};
        if (ri != 2'd3 && cj != 2'd3) begin
          sub[i][j] = cur_q.win[ri][cj];
        end else begin
          sub[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    ctr  = sub[1][1];
    hsum = (vl ? 10'(sub[1][0]) : 10'd0) + (vr ? 10'(sub[1][2]) : 10'd0);
    hcnt = 3'(vl) + 3'(vr);
    vsum = (vt ? 10'(sub[0][1]) : 10'd0) + (vb ? 10'(sub[2][1]) : 10'd0);
    vcnt = 3'(vt) + 3'(vb);
    xsum = hsum + vsum;
    xcnt = hcnt + vcnt;
    dsum = ((vt & vl) ? 10'(sub[0][0]) : 10'd0) + ((vt & vr) ? 10'(sub[0][2]) : 10'd0) +
           ((vb & vl) ? 10'(sub[2][0]) : 10'd0) + ((vb & vr) ? 10'(sub[2][2]) : 10'd0);
    dcnt = 3'(vt & vl) + 3'(vt & vr) + 3'(vb & vl) + 3'(vb & vr);
  end

  assign colour = colour_at(jrow[0], jcol[0]);

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    unique case (colour)
      ColGreen: begin
        sum_d[ColGreen] = 10'(ctr);
        cnt_d[ColGreen] = 3'd1;
        if (!jrow[0]) begin
          sum_d[ColRed]  = vsum;
          cnt_d[ColRed]  = vcnt;
          sum_d[ColBlue] = hsum;
          cnt_d[ColBlue] = hcnt;
        end else begin
          sum_d[ColRed]  = hsum;
          cnt_d[ColRed]  = hcnt;
          sum_d[ColBlue] = vsum;
          cnt_d[ColBlue] = vcnt;
        end
      end
      ColBlue: begin
        sum_d[ColBlue]  = 10'(ctr);
        cnt_d[ColBlue]  = 3'd1;
        sum_d[ColGreen] = xsum;
        cnt_d[ColGreen] = xcnt;
        sum_d[ColRed]   = dsum;
        cnt_d[ColRed]   = dcnt;
      end
      ColRed: begin
        sum_d[ColRed]   = 10'(ctr);
        cnt_d[ColRed]   = 3'd1;
        sum_d[ColGreen] = xsum;
        cnt_d[ColGreen] = xcnt;
        sum_d[ColBlue]  = dsum;
        cnt_d[ColBlue]  = dcnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q     <= 1'b0;
      rem_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (load) begin
        hold_q <= 1'b1;
        rem_q  <= desc_i.mask;
      end else if (issue) begin
        rem_q <= rem_next;
        if (rem_next == '0) begin
          hold_q <= 1'b0;
        end
      end
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= desc_i;
    end
    if (issue) begin
      s1_sum_q  <= sum_d;
      s1_cnt_q  <= cnt_d;
      s1_row_q  <= jrow;
      s1_col_q  <= jcol;
      s1_last_q <= (rem_next == '0);
      s1_done_q <= done;
    end
  end

  assign oq_wdata.red   = avg_div(s1_sum_q[ColRed], s1_cnt_q[ColRed]);
  assign oq_wdata.green = avg_div(s1_sum_q[ColGreen], s1_cnt_q[ColGreen]);
  assign oq_wdata.blue  = avg_div(s1_sum_q[ColBlue], s1_cnt_q[ColBlue]);
  assign oq_wdata.row   = s1_row_q;
  assign oq_wdata.col   = s1_col_q;
  assign oq_wdata.last  = s1_last_q;
  assign oq_wdata.done  = s1_done_q;

  bgd_fifo #(
    .W     ($bits(pix_t)),
    .DEPTH (PixDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .wdata_i (oq_wdata),
    .pop_i   (pop_i),
    .rdata_o (pix_o),
    .full_o  (oq_full),
    .empty_o (empty_o),
    .count_o (oq_cnt)
  );

  logic unused_full;
  assign unused_full = oq_full;

endmodule

`default_nettype wire

// ===== hdl/bayer_gbrg_demosaic.sv =====
// GBRG Bayer demosaic, 3x3 neighbor average, streaming in raster order.
// Input channel: drive raw_pixel_i and push; a transfer happens on a rising
// edge with push high and full low. Result channel: while empty is low the
// oldest result sits on red_o, green_o, blue_o, out_row_o, out_column_o,
// last_of_run_o and frame_done_o; pop with empty low transfers it.
// Config: cfg_we_i writes cfg_data_i to register cfg_index_i (0 line width,
// 1 frame height) at once and restarts the frame at row 0, column 0.
// An input sample passes two front-end steps (line buffer read, then line
// buffer write and window shift); full is high during the second, so no
// new sample is taken while one is in the front end. It releases zero to
// four results; the back end loads its descriptor, then issues them one by
// one while its result queue has room, so at a row end or along the last
// row, where a sample releases two or more, the pace drops. Results pass
// the input, descriptor and result stage registers and both queues. A
// two-entry descriptor queue and a four-entry result queue absorb stalls:
// while pop stays low, the back end stops once its result queue fills,
// then the descriptor queue fills and full rises.
// Reset restores 640 x 480, clears position and queues; line buffers keep
// their contents and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module bayer_gbrg_demosaic
  import bgd_pkg::*;
#(
  parameter int unsigned MAX_LINE = MaxLineDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          raw_pixel_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic      [7:0]          red_o,
  output logic      [7:0]          green_o,
  output logic      [7:0]          blue_o,
  output logic      [15:0]         out_row_o,
  output logic      [10:0]         out_column_o,
  output logic                     last_of_run_o,
  output logic                     frame_done_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  desc_t desc_in, desc_out;
  logic  desc_push, desc_pop, desc_full, desc_empty;
  pix_t  pix;
  logic [$clog2(DescDepth + 1)-1:0] desc_cnt;

  bgd_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .raw_pixel_i (raw_pixel_i),
    .full_o      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .desc_o      (desc_in),
    .desc_push_o (desc_push),
    .desc_full_i (desc_full)
  );

  bgd_fifo #(
    .W     ($bits(desc_t)),
    .DEPTH (DescDepth)
  ) u_desc_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc_in),
    .pop_i   (desc_pop),
    .rdata_o (desc_out),
    .full_o  (desc_full),
    .empty_o (desc_empty),
    .count_o (desc_cnt)
  );

  bgd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc_out),
    .desc_empty_i (desc_empty),
    .desc_pop_o   (desc_pop),
    .pix_o        (pix),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  logic unused_cnt;
  assign unused_cnt = ^desc_cnt;

  assign red_o         = pix.red;
  assign green_o       = pix.green;
  assign blue_o        = pix.blue;
  assign out_row_o     = pix.row;
  assign out_column_o  = pix.col;
  assign last_of_run_o = pix.last;
  assign frame_done_o  = pix.done;

endmodule

`default_nettype wire

// ===== tb/demosaic_checker.sv =====
`timescale 1ns / 1ps

module demosaic_checker
  import bgd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic                full_i,
  input  wire logic [7:0]          raw_pixel_i,
  input  wire logic                empty_i,
  input  wire logic                pop_i,
  input  wire logic [7:0]          red_i,
  input  wire logic [7:0]          green_i,
  input  wire logic [7:0]          blue_i,
  input  wire logic [15:0]         out_row_i,
  input  wire logic [10:0]         out_column_i,
  input  wire logic                last_of_run_i,
  input  wire logic                frame_done_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       checked_o
);

  localparam int LineSlots = MaxLineDef;

  logic [7:0]  line_mem [3][LineSlots];
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  int          row_pos;
  int          col_pos;
  int          fail_count;
  int          result_count;
  pix_t        expected_pixels [$];

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = 8'd0;
    fail_count   = 0;
    result_count = 0;
  end

  function automatic colour_e hue_of(input int r, input int c);
    case ({r[0], c[0]})
      2'b00:   return ColGreen;
      2'b01:   return ColBlue;
      2'b10:   return ColRed;
      default: return ColGreen;
    endcase
  endfunction

  function automatic pix_t demosaic_at(input int r, input int c, input int w, input int h);
    int         sum [3];
    int         cnt [3];
    int         x;
    int         y;
    logic [7:0] chan [3];
    pix_t       p;
    for (int k = 0; k < 3; k++) begin
      sum[k] = 0;
      cnt[k] = 0;
    end
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        x = r + dr;
        y = c + dc;
        if (x >= 0 && y >= 0 && x < h && y < w) begin
          sum[int'(hue_of(x, y))] += int'(line_mem[x % 3][y]);
          cnt[int'(hue_of(x, y))] += 1;
        end
      end
    end
    for (int k = 0; k < 3; k++) chan[k] = (cnt[k] != 0) ? 8'(sum[k] / cnt[k]) : 8'd0;
    chan[int'(hue_of(r, c))] = line_mem[r % 3][c];
    p.red   = chan[int'(ColRed)];
    p.green = chan[int'(ColGreen)];
    p.blue  = chan[int'(ColBlue)];
    p.row   = 16'(r);
    p.col   = 11'(c);
    p.last  = 1'b0;
    p.done  = (r == h - 1 && c == w - 1);
    return p;
  endfunction

  task automatic predict_sample(input logic [7:0] px);
    int   w;
    int   h;
    int   r;
    int   c;
    pix_t run_q [$];
    w = int'(width_reg);
    if (w < 2) w = 2;
    if (w > LineSlots) w = LineSlots;
    h = int'(height_reg);
    if (h < 2) h = 2;
    r = row_pos;
    c = col_pos;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    line_mem[r % 3][c] = px;
    if (r >= 1) begin
      if (c >= 1) run_q.push_back(demosaic_at(r - 1, c - 1, w, h));
      if (c == w - 1) run_q.push_back(demosaic_at(r - 1, c, w, h));
    end
    if (r == h - 1) begin
      if (c >= 1) run_q.push_back(demosaic_at(r, c - 1, w, h));
      if (c == w - 1) run_q.push_back(demosaic_at(r, c, w, h));
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) expected_pixels.push_back(run_q[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic check_result(input pix_t got);
    pix_t want;
    result_count++;
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result rgb %0d/%0d/%0d at (%0d,%0d) last %0b done %0b",
                 got.red, got.green, got.blue, got.row, got.col, got.last, got.done);
      end
    end else begin
      want = expected_pixels.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected rgb %0d/%0d/%0d at (%0d,%0d) last %0b done %0b",
                   want.red, want.green, want.blue, want.row, want.col, want.last,
                   want.done);
          $display("          actual   rgb %0d/%0d/%0d at (%0d,%0d) last %0b done %0b",
                   got.red, got.green, got.blue, got.row, got.col, got.last, got.done);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      expected_pixels.delete();
      width_reg  = LineWidthRst;
      height_reg = FrameHeightRst;
      row_pos    = 0;
      col_pos    = 0;
    end else begin
      if (pop_i && !empty_i) begin
        check_result({red_i, green_i, blue_i, out_row_i, out_column_i,
                      last_of_run_i, frame_done_i});
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgLineWidth) width_reg = cfg_data_i[11:0];
        else if (cfg_index_i == CfgFrameHeight) height_reg = cfg_data_i;
        row_pos = 0;
        col_pos = 0;
      end else if (push_i && !full_i) begin
        predict_sample(raw_pixel_i);
      end
    end
    errors_o  <= fail_count;
    pending_o <= expected_pixels.size();
    checked_o <= result_count;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bgd_pkg::*;

  localparam int DrainCycles = 16;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                push      = 1'b0;
  logic                full;
  logic [7:0]          raw_pixel = 8'd0;
  logic                empty;
  logic                pop       = 1'b0;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic [15:0]         out_row;
  logic [10:0]         out_column;
  logic                last_of_run;
  logic                frame_done;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CfgLineWidth;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int checked;
  int send_idle_pct = 14;
  int recv_idle_pct = 84;
  int pixels_sent   = 0;
  int reg_writes    = 0;

  bayer_gbrg_demosaic uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .raw_pixel_i  (raw_pixel),
    .empty        (empty),
    .pop          (pop),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .out_row_o    (out_row),
    .out_column_o (out_column),
    .last_of_run_o(last_of_run),
    .frame_done_o (frame_done),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  demosaic_checker pixel_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .raw_pixel_i  (raw_pixel),
    .empty_i      (empty),
    .pop_i        (pop),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_row_i    (out_row),
    .out_column_i (out_column),
    .last_of_run_i(last_of_run),
    .frame_done_i (frame_done),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic push_pixel(input logic [7:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      push      <= 1'b0;
      raw_pixel <= 8'($urandom);
      @(posedge clk);
    end
    push      <= 1'b1;
    raw_pixel <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic feed_pixels(input int count);
    for (int i = 0; i < count; i++) push_pixel(pick_pixel());
  endtask

  // hold off until every result is out and the front end has settled
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CfgDataW-1:0] wd, input logic [CfgDataW-1:0] hd);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CfgLineWidth;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= CfgFrameHeight;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_we     <= 1'b0;
    reg_writes += 2;
  endtask

  task automatic random_frames(input int budget);
    int sent;
    int w;
    int h;
    int n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) begin
        w = $urandom_range(10, 16);
        h = $urandom_range(2, 3);
      end else begin
        w = $urandom_range(2, 8);
        h = $urandom_range(2, 5);
      end
      set_frame({4'($urandom), 12'(w)}, 16'(h));
      n = $urandom_range(1, 2) * w * h;
      // drop the frame part way through now and then
      if ($urandom_range(5) == 0) n = $urandom_range(1, w * h - 1);
      if (n > budget - sent) n = budget - sent;
      feed_pixels(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_frame(16'd2, 16'd2);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'hFF);
    push_pixel(8'h00);

    set_frame(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) push_pixel((i % 2) ? 8'hFF : 8'h00);

    set_frame(16'd0, 16'd1);
    for (int i = 0; i < 4; i++) push_pixel(8'hFF);

    set_frame(16'hF001, 16'hFFFF);
    for (int i = 0; i < 8; i++) push_pixel((i % 3) ? 8'h00 : 8'hFF);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_frames(40);
    end

    set_frame(16'h0FFF, 16'd2);
    feed_pixels(8);
    set_frame(16'd5, 16'd4);
    feed_pixels(20);

    wait_idle();
    $display("run covered %0d pixels over %0d register writes, %0d results checked",
             pixels_sent, reg_writes, checked);
    $display("frame sizes from 2x2 up to 16 wide, clamped and masked settings included");
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== bayer_gbrg_demosaic.f =====
hdl/bgd_pkg.sv
hdl/bgd_ram.sv
hdl/bgd_fifo.sv
hdl/bgd_front.sv
hdl/bgd_back.sv
hdl/bayer_gbrg_demosaic.sv
tb/demosaic_checker.sv
tb/testbench.sv
